[rtl/core/haa_pkg.sv]
// Shared constants, codes and the byte-wise CRC-16 function for the address assigner.
`default_nettype none

package haa_pkg;

   // Identifier length in bytes (1 to 15, counter is 4 bits wide)
   localparam int ID_BYTES = 8;
   localparam int CNT_W    = 4;
   localparam int ADDR_W   = 16;

   localparam logic [ADDR_W-1:0] CRC_POLY       = 16'h1021;
   localparam logic [ADDR_W-1:0] CRC_MSB        = 16'h8000;
   localparam logic [ADDR_W-1:0] LIMIT_RESET    = 16'd256;

   // Input operation codes
   localparam logic OP_ID_BYTE = 1'b0;
   localparam logic OP_PROBE   = 1'b1;

   // Result kind codes
   localparam logic KIND_PROBE    = 1'b0;
   localparam logic KIND_ASSIGNED = 1'b1;

   // One identifier byte into the CRC-16, MSB first, eight shift steps
   function automatic logic [ADDR_W-1:0] crc_byte(input logic [ADDR_W-1:0] acc,
                                                  input logic [7:0] b);
      logic [ADDR_W-1:0] c;
      c = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != '0) begin
            c = {c[ADDR_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[ADDR_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/hashed_address_assigner.sv]
// Top level: CRC-16 short address derivation with probe-driven collision stepping.
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_op, req_id_byte, req_probe_acked
// rsp       out        rsp_valid/rsp_ready  rsp_kind, rsp_address
// csr       in         csr_valid/csr_ready  csr_reserved_limit
//
// An item is taken into the input register, processed by the CRC and candidate
// logic and, if it causes a result, lands in the output register. Sustained rate
// is one item per cycle while the output register is not stalled by rsp.
// The output register parts the two sides: a stalled rsp only blocks items that
// produce a result. Reset is synchronous and clears control state and the limit
// to 256. The csr port is always ready.

module hashed_address_assigner #(
   parameter int ID_BYTES = haa_pkg::ID_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_id_byte,
   input  wire logic        req_probe_acked,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [15:0]      rsp_address,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_reserved_limit
);

   localparam int AW = haa_pkg::ADDR_W;
   localparam int CW = haa_pkg::CNT_W;

   // Configuration register
   logic [AW-1:0] limit_ff;

   // Input register
   logic          in_vld_ff, in_vld_in;
   logic          in_op_ff;
   logic [7:0]    in_byte_ff;
   logic          in_ack_ff;

   // Assignment state
   logic [AW-1:0] crc_ff, crc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    last_ff, last_in;
   logic [AW-1:0] cand_ff, cand_in;
   logic          await_ff, await_in;

   // Output register
   logic          out_vld_ff, out_vld_in;
   logic          out_kind_ff, out_kind_in;
   logic [AW-1:0] out_addr_ff, out_addr_in;

   logic          has_result;
   logic          advance;
   logic [AW-1:0] crc_next;
   logic [CW-1:0] cnt_next;

   assign csr_ready = 1'b1;

   // Processing of the item held in the input register
   always_comb begin
      crc_next    = haa_pkg::crc_byte(crc_ff, in_byte_ff);
      cnt_next    = cnt_ff + CW'(1);
      crc_in      = crc_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      cand_in     = cand_ff;
      await_in    = await_ff;
      has_result  = 1'b0;
      out_kind_in = haa_pkg::KIND_PROBE;
      out_addr_in = cand_ff;
      if (in_op_ff == haa_pkg::OP_ID_BYTE) begin
         if (!await_ff) begin
            last_in = in_byte_ff;
            if (cnt_next == CW'(ID_BYTES)) begin
               // last byte: a hash below the limit is raised by the limit, mod 2^16
               if (crc_next < limit_ff) begin
                  cand_in = crc_next + limit_ff;
               end else begin
                  cand_in = crc_next;
               end
               crc_in      = '0;
               cnt_in      = '0;
               await_in    = 1'b1;
               has_result  = 1'b1;
               out_addr_in = cand_in;
            end else begin
               crc_in = crc_next;
               cnt_in = cnt_next;
            end
         end
      end else begin
         if (await_ff) begin
            has_result = 1'b1;
            if (in_ack_ff) begin
               // address taken: step by one plus the last identifier byte
               cand_in     = cand_ff + AW'(1) + AW'(last_ff);
               out_addr_in = cand_in;
            end else begin
               await_in    = 1'b0;
               crc_in      = '0;
               cnt_in      = '0;
               out_kind_in = haa_pkg::KIND_ASSIGNED;
            end
         end
      end
   end

   // Flow control between input and output registers
   assign advance    = in_vld_ff && (!has_result || !out_vld_ff || rsp_ready);
   assign req_ready  = !in_vld_ff || advance;
   assign in_vld_in  = req_valid && req_ready ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = (advance && has_result) ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= haa_pkg::LIMIT_RESET;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         crc_ff     <= '0;
         cnt_ff     <= '0;
         last_ff    <= '0;
         cand_ff    <= '0;
         await_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_reserved_limit;
         end
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            crc_ff   <= crc_in;
            cnt_ff   <= cnt_in;
            last_ff  <= last_in;
            cand_ff  <= cand_in;
            await_ff <= await_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_id_byte;
         in_ack_ff  <= req_probe_acked;
      end
      if (advance && has_result) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_kind    = out_kind_ff;
   assign rsp_address = out_addr_ff;

   // Byte count never reaches the identifier length
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CW'(ID_BYTES))
      else $error("byte count reached identifier length");

   // While waiting for a probe the CRC and count are cleared
   a_await_clear: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> (crc_ff == '0) && (cnt_ff == '0))
      else $error("CRC state not cleared while awaiting probe");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |-> !(advance && has_result))
      else $error("pending result overwritten");

   // Entering the probe phase always comes with a probe result
   a_await_rise: assert property (@(posedge clock) disable iff (reset)
      (advance && !await_ff && await_in) |=>
         (out_vld_ff && (out_kind_ff == haa_pkg::KIND_PROBE) && (out_addr_ff == cand_ff)))
      else $error("probe phase entered without candidate result");

   // An assignment result ends the probe phase
   a_assign_end: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && (out_kind_in == haa_pkg::KIND_ASSIGNED)) |=> !await_ff)
      else $error("probe phase kept after assignment");

endmodule

`default_nettype wire

[tb/tb_hashed_address_assigner.sv]
// Testbench for the hashed address assigner: directed table, random identifier runs, scoreboard.
`timescale 1ns / 100ps

module tb_hashed_address_assigner;

   // How a stimulus row is checked
   typedef enum bit [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_type;

   typedef struct {
      bit            op;
      bit [7:0]      id_byte;
      bit            acked;
      row_check_type chk;
      bit            kind;
      bit [15:0]     addr;
   } stim_row_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
   } addr_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [7:0]  req_id_byte;
   logic        req_probe_acked;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [15:0] rsp_address;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_reserved_limit;

   // Address predictor state
   bit [15:0] limit_reg = haa_pkg::LIMIT_RESET;
   bit [15:0] crc_run   = '0;
   bit [3:0]  id_count  = '0;
   bit [7:0]  tail_byte = '0;
   bit [15:0] cand_addr = '0;
   bit        probing   = 1'b0;

   addr_result_type expected_addrs[$];

   bit idle_on      = 1'b1;
   int bad_count    = 0;
   int used_items   = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int assigned_cnt = 0;
   int acked_cnt    = 0;
   int limit_writes = 0;

   hashed_address_assigner dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_id_byte        (req_id_byte),
      .req_probe_acked    (req_probe_acked),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_address        (rsp_address),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_reserved_limit (csr_reserved_limit)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Address predictor: returns 1 when the item yields a result, used = item not ignored
   function automatic bit predict_address(input bit op, input bit [7:0] b, input bit acked,
                                          output bit kind, output bit [15:0] addr,
                                          output bit used);
      bit [15:0] c;
      bit        fb;
      int        i;
      kind = haa_pkg::KIND_PROBE;
      addr = '0;
      used = 1'b0;
      if (op == haa_pkg::OP_ID_BYTE) begin
         if (probing) return 1'b0;
         used = 1'b1;
         // bit-serial CRC-16, MSB of the byte first
         c = crc_run;
         for (i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ haa_pkg::CRC_POLY;
         end
         crc_run   = c;
         tail_byte = b;
         id_count  = id_count + 4'd1;
         if (id_count != 4'(haa_pkg::ID_BYTES)) return 1'b0;
         // hash in the manual range is raised by the limit, mod 2^16
         cand_addr = (c < limit_reg) ? c + limit_reg : c;
         crc_run   = '0;
         id_count  = '0;
         probing   = 1'b1;
         addr      = cand_addr;
         return 1'b1;
      end
      if (!probing) return 1'b0;
      used = 1'b1;
      if (acked) begin
         // address taken: step past it, wrapping
         cand_addr = cand_addr + 16'd1 + 16'(tail_byte);
         addr      = cand_addr;
         return 1'b1;
      end
      probing  = 1'b0;
      crc_run  = '0;
      id_count = '0;
      kind     = haa_pkg::KIND_ASSIGNED;
      addr     = cand_addr;
      return 1'b1;
   endfunction

   // One req transfer, with an optional idle burst ahead of it
   task automatic drive_item(input stim_row_type row);
      bit        got;
      bit        kind;
      bit        used;
      bit [15:0] addr;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= row.op;
      req_id_byte     <= row.id_byte;
      req_probe_acked <= row.acked;
      do @(posedge clock); while (!req_ready);
      got = predict_address(row.op, row.id_byte, row.acked, kind, addr, used);
      items_sent++;
      if (used) used_items++;
      if (got && kind == haa_pkg::KIND_ASSIGNED) assigned_cnt++;
      if (got && kind == haa_pkg::KIND_PROBE && row.op == haa_pkg::OP_PROBE) acked_cnt++;
      if (row.chk == CHK_FIXED) begin
         expected_addrs.push_back(addr_result_type'{row.kind, row.addr});
      end else if (row.chk == CHK_MODEL && got) begin
         expected_addrs.push_back(addr_result_type'{kind, addr});
      end
   endtask

   // Drop valid, let outstanding results come back, then cover the pipeline latency
   task automatic drain();
      int w;
      req_valid <= 1'b0;
      for (w = 0; w < 4000 && expected_addrs.size() != 0; w++) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(input bit [15:0] value);
      drain();
      csr_valid          <= 1'b1;
      csr_reserved_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   // Random part: mostly whole identifiers followed by probe chains
   task automatic run_random(input int quota);
      int       start;
      int       k;
      int       n;
      bit [7:0] b;
      start = used_items;
      while (used_items - start < quota) begin
         case ($urandom_range(0, 9))
            0: begin
               // noise item
               drive_item(stim_row_type'{1'($urandom), 8'($urandom), 1'($urandom),
                                         CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
            end
            1: begin
               // cut-short identifier, then a probe item
               n = $urandom_range(1, haa_pkg::ID_BYTES - 1);
               for (k = 0; k < n; k++) begin
                  drive_item(stim_row_type'{haa_pkg::OP_ID_BYTE, 8'($urandom), 1'($urandom),
                                            CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
               end
               drive_item(stim_row_type'{haa_pkg::OP_PROBE, 8'($urandom), 1'($urandom),
                                         CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
            end
            default: begin
               // close an open probe chain first
               if (probing) begin
                  drive_item(stim_row_type'{haa_pkg::OP_PROBE, 8'($urandom), 1'b0,
                                            CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
               end
               for (k = 0; k < haa_pkg::ID_BYTES; k++) begin
                  case ($urandom_range(0, 9))
                     0:       b = 8'h00;
                     1:       b = 8'hFF;
                     default: b = 8'($urandom);
                  endcase
                  drive_item(stim_row_type'{haa_pkg::OP_ID_BYTE, b, 1'($urandom),
                                            CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
               end
               n = $urandom_range(0, 6);
               for (k = 0; k < n; k++) begin
                  drive_item(stim_row_type'{haa_pkg::OP_PROBE, 8'($urandom), 1'b1,
                                            CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
               end
               drive_item(stim_row_type'{haa_pkg::OP_PROBE, 8'($urandom), 1'b0,
                                         CHK_MODEL, haa_pkg::KIND_PROBE, 16'h0});
            end
         endcase
      end
   endtask

   // Receiver backpressure in random bursts
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Result scoreboard
   always @(posedge clock) begin : rsp_check
      addr_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_addrs.size() == 0) begin
            if (bad_count < 10) begin
               $display("%0t: unexpected result kind=%0d address=%h",
                        $realtime, rsp_kind, rsp_address);
            end
            bad_count++;
         end else begin
            want = expected_addrs.pop_front();
            if (want.kind !== rsp_kind || want.addr !== rsp_address) begin
               if (bad_count < 10) begin
                  $display("%0t: mismatch: expected kind=%0d address=%h,",
                           $realtime, want.kind, want.addr,
                           " got kind=%0d address=%h", rsp_kind, rsp_address);
               end
               bad_count++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("hashed_address_assigner regression: fail");
      $finish;
   end

   // Main sequence
   initial begin
      stim_row_type dir_rows[$];
      bit [15:0]    limit_plan[$];
      int           i;
      int           p;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_op             <= haa_pkg::OP_ID_BYTE;
      req_id_byte        <= 8'h00;
      req_probe_acked    <= 1'b0;
      csr_valid          <= 1'b0;
      csr_reserved_limit <= 16'h0000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // probe items while collecting are dropped
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'hA5, 1'b1, CHK_NONE,
                                        haa_pkg::KIND_PROBE, 16'h0});
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'h5A, 1'b0, CHK_NONE,
                                        haa_pkg::KIND_PROBE, 16'h0});
      // all-zero identifier: CRC stays zero, raised by the reset limit
      for (i = 0; i < haa_pkg::ID_BYTES - 1; i++) begin
         dir_rows.push_back(stim_row_type'{haa_pkg::OP_ID_BYTE, 8'h00, 1'b1, CHK_NONE,
                                           haa_pkg::KIND_PROBE, 16'h0});
      end
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_ID_BYTE, 8'h00, 1'b0, CHK_FIXED,
                                        haa_pkg::KIND_PROBE, 16'h0100});
      // identifier byte while a probe is pending is dropped
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_ID_BYTE, 8'hFF, 1'b1, CHK_NONE,
                                        haa_pkg::KIND_PROBE, 16'h0});
      // last byte was zero, so each taken probe steps by one
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'hFF, 1'b1, CHK_FIXED,
                                        haa_pkg::KIND_PROBE, 16'h0101});
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'h00, 1'b1, CHK_FIXED,
                                        haa_pkg::KIND_PROBE, 16'h0102});
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'hFF, 1'b0, CHK_FIXED,
                                        haa_pkg::KIND_ASSIGNED, 16'h0102});
      // all-ones identifier, steps of 256
      for (i = 0; i < haa_pkg::ID_BYTES; i++) begin
         dir_rows.push_back(stim_row_type'{haa_pkg::OP_ID_BYTE, 8'hFF, 1'b0, CHK_MODEL,
                                           haa_pkg::KIND_PROBE, 16'h0});
      end
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'h00, 1'b1, CHK_MODEL,
                                        haa_pkg::KIND_PROBE, 16'h0});
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'h00, 1'b1, CHK_MODEL,
                                        haa_pkg::KIND_PROBE, 16'h0});
      dir_rows.push_back(stim_row_type'{haa_pkg::OP_PROBE, 8'h00, 1'b0, CHK_MODEL,
                                        haa_pkg::KIND_PROBE, 16'h0});

      foreach (dir_rows[i]) drive_item(dir_rows[i]);

      // limit settings: none, all-ones (raise wraps), one, half range, random, reset value
      limit_plan.push_back(16'h0000);
      limit_plan.push_back(16'hFFFF);
      limit_plan.push_back(16'h0001);
      limit_plan.push_back(16'h8000);
      limit_plan.push_back(16'($urandom));
      limit_plan.push_back(haa_pkg::LIMIT_RESET);

      foreach (limit_plan[p]) begin
         write_limit(limit_plan[p]);
         // last phase runs with both sides streaming
         if (p == limit_plan.size() - 1) idle_on = 1'b0;
         run_random(215);
      end

      drain();
      if (expected_addrs.size() != 0) begin
         $display("%0d expected results never arrived", expected_addrs.size());
         bad_count += expected_addrs.size();
      end

      $display("%0d items sent (%0d not ignored), %0d results checked, %0d taken-probe steps",
               items_sent, used_items, results_seen, acked_cnt);
      $display("%0d addresses assigned across %0d limit settings, %0d mismatches",
               assigned_cnt, limit_writes, bad_count);
      if (bad_count == 0) begin
         $display("hashed_address_assigner regression: pass");
      end else begin
         $display("hashed_address_assigner regression: fail");
      end
      $finish;
   end

endmodule
